FILE: rtl/core/sorted_id_binary_search_assert.svh
// Assertion macros for the checker module of the search block.
`ifndef SORTED_ID_BINARY_SEARCH_ASSERT_SVH
`define SORTED_ID_BINARY_SEARCH_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sib assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SIB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sib assertion failed");

`endif

FILE: rtl/core/sib_pkg.sv
package sib_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int COUNT_W     = 11;
    localparam int POS_W       = 10;
    localparam int ID_W        = 32;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [ID_W-1:0]   wdata;
    } ram_req_t;

endpackage

FILE: rtl/core/sorted_id_binary_search.sv
// A write beat does not stall the input, so the next beat can be taken at once.
// A search beat probes at most 11 entries for a full table of 1024, each probe reading
// the single-port table memory in the probe state and comparing in the compare state.
// Input stalls until the result is loaded into the output register, so the next beat
// can be taken in the same cycle as the result appears.
// Reset clears the sequencer, the output valid and entry_count; table contents are kept.
module sorted_id_binary_search (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        entry_count_we,
    input  logic [10:0] entry_count,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [9:0]  entry_index,
    input  logic [31:0] entry_id,
    input  logic [31:0] search_key,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        found,
    output logic [9:0]  position
);
    import sib_pkg::*;

    logic [COUNT_W-1:0] entry_count_reg;
    logic [COUNT_W-1:0] entry_count_next;
    logic [COUNT_W-1:0] live_count;
    ram_req_t           ram_req;
    logic [ID_W-1:0]    ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else
        begin
            entry_count_reg <= entry_count_next;
        end
    end

    always_comb
    begin
        entry_count_next = entry_count_we ? entry_count : entry_count_reg;
        if (32'(entry_count_reg) > 32'(TABLE_DEPTH))
        begin
            live_count = COUNT_W'(TABLE_DEPTH);
        end
        else
        begin
            live_count = entry_count_reg;
        end
    end

    sib_search_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .live_count  (live_count),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .entry_index (entry_index),
        .entry_id    (entry_id),
        .search_key  (search_key),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found       (found),
        .position    (position),
        .ram_req     (ram_req),
        .ram_rdata   (ram_rdata)
    );

    sib_table_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

endmodule

FILE: rtl/core/sib_table_ram.sv
module sib_table_ram (
    input  logic               clk,
    input  sib_pkg::ram_req_t  req,
    output logic [31:0]        rdata
);
    import sib_pkg::*;

    logic [ID_W-1:0] id_table_reg [TABLE_DEPTH];
    logic [ID_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            id_table_reg[req.addr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= id_table_reg[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/sib_search_ctrl.sv
module sib_search_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [10:0]        live_count,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               op,
    input  logic [9:0]         entry_index,
    input  logic [31:0]        entry_id,
    input  logic [31:0]        search_key,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               found,
    output logic [9:0]         position,
    output sib_pkg::ram_req_t  ram_req,
    input  logic [31:0]        ram_rdata
);
    import sib_pkg::*;

    state_t              state_reg,     state_next;
    logic [COUNT_W-1:0]  lo_reg,        lo_next;
    logic [COUNT_W-1:0]  hi_reg,        hi_next;
    logic [ADDR_W-1:0]   mid_reg,       mid_next;
    logic [ID_W-1:0]     key_reg,       key_next;
    logic                res_found_reg, res_found_next;
    logic [POS_W-1:0]    res_pos_reg,   res_pos_next;
    logic                out_valid_reg, out_valid_next;
    logic                found_reg,     found_next;
    logic [POS_W-1:0]    position_reg,  position_next;

    logic                accept;
    logic                index_ok;
    logic [COUNT_W:0]    mid_sum;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign index_ok = (32'(entry_index) < 32'(TABLE_DEPTH));
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg} - (COUNT_W + 1)'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        key_reg       <= key_next;
        res_found_reg <= res_found_next;
        res_pos_reg   <= res_pos_next;
        found_reg     <= found_next;
        position_reg  <= position_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        key_next       = key_reg;
        res_found_next = res_found_reg;
        res_pos_next   = res_pos_reg;
        found_next     = found_reg;
        position_next  = position_reg;
        out_valid_next = out_valid_reg && out_stall;
        ram_req        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (op == OP_SEARCH)
                    begin
                        lo_next    = '0;
                        hi_next    = live_count;
                        key_next   = search_key;
                        state_next = ST_PROBE;
                    end
                    else
                    begin
                        ram_req.we    = index_ok;
                        ram_req.addr  = entry_index[ADDR_W-1:0];
                        ram_req.wdata = entry_id;
                    end
                end
            end
            ST_PROBE:
            begin
                if (lo_reg >= hi_reg)
                begin
                    res_found_next = 1'b0;
                    res_pos_next   = '0;
                    state_next     = ST_DONE;
                end
                else
                begin
                    mid_next     = mid_sum[ADDR_W:1];
                    ram_req.re   = 1'b1;
                    ram_req.addr = mid_sum[ADDR_W:1];
                    state_next   = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (key_reg == ram_rdata)
                begin
                    res_found_next = 1'b1;
                    res_pos_next   = POS_W'(mid_reg);
                    state_next     = ST_DONE;
                end
                else
                begin
                    if (key_reg < ram_rdata)
                    begin
                        hi_next = COUNT_W'(mid_reg);
                    end
                    else
                    begin
                        lo_next = COUNT_W'(mid_reg) + COUNT_W'(1);
                    end
                    state_next = ST_PROBE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    found_next     = res_found_reg;
                    position_next  = res_pos_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign position  = position_reg;

endmodule

FILE: rtl/core/sib_checker.sv
`include "sorted_id_binary_search_assert.svh"

module sib_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        op,
    input logic        out_valid,
    input logic        out_stall,
    input logic        found,
    input logic [9:0]  position
);
    import sib_pkg::*;

    // A stalled result beat keeps its payload.
    `SIB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(found) && $stable(position))

    // A miss always reports position zero.
    `SIB_ASSERT_NOW(a_miss_pos_zero, out_valid && !found, position == '0)

    // An accepted search occupies the block in the following cycle.
    `SIB_ASSERT_NEXT(a_search_busy, in_valid && !in_stall && (op == OP_SEARCH), in_stall)

    // An accepted write leaves the block free for the next beat.
    `SIB_ASSERT_NEXT(a_write_free, in_valid && !in_stall && (op == OP_WRITE), !in_stall)

endmodule

bind sorted_id_binary_search sib_checker u_sib_checker (.*);
